>>> hw/rtl/twsp_pkg.sv
// Shared widths, option codes and limits for the TCP window-scale option parser.
`timescale 1ns / 1ps

package twsp_pkg;

   localparam int unsigned OPT_BYTE_W = 8;
   localparam int unsigned AREA_LEN_W = 6;
   localparam int unsigned SHIFT_W    = 4;

   localparam int unsigned MAX_AREA_BYTES_DEF = 40;

   localparam logic [OPT_BYTE_W-1:0] KIND_EOL    = 8'd0;
   localparam logic [OPT_BYTE_W-1:0] KIND_NOP    = 8'd1;
   localparam logic [OPT_BYTE_W-1:0] KIND_WSCALE = 8'd3;
   localparam logic [OPT_BYTE_W-1:0] WSCALE_LEN  = 8'd3;
   localparam logic [OPT_BYTE_W-1:0] MIN_OPT_LEN = 8'd2;
   localparam logic [OPT_BYTE_W-1:0] SHIFT_CAP   = 8'd14;

endpackage

>>> hw/rtl/twsp_if.sv
// Valid/ready channel interfaces for the option byte stream and the shift results.
`timescale 1ns / 1ps

interface twsp_req_if;
   import twsp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OPT_BYTE_W-1:0] opt_byte;
   logic                  area_start;
   logic [AREA_LEN_W-1:0] area_len;

   modport source (output valid, output opt_byte, output area_start, output area_len,
                   input ready);
   modport sink   (input valid, input opt_byte, input area_start, input area_len,
                   output ready);
endinterface

interface twsp_rsp_if;
   import twsp_pkg::*;

   logic               valid;
   logic               ready;
   logic [SHIFT_W-1:0] window_shift;

   modport source (output valid, output window_shift, input ready);
   modport sink   (input valid, input window_shift, output ready);
endinterface

>>> hw/rtl/tcp_window_scale_option_parser.sv
// Top level of the TCP window-scale option parser.
`timescale 1ns / 1ps

// Walks a TCP options area that arrives one byte per item and returns one window_shift
// per completed area: on the area's final byte, or at once for a start byte with
// area_len 0. The parser takes one item every cycle while req ready is high; each
// byte updates the parse state in a single register stage, and an area's result
// is registered. A two-entry output stage (result register plus skid register)
// lets the request side keep flowing while a result waits; req ready drops only while
// both entries hold results. area_len values above MAX_AREA_BYTES are treated as
// MAX_AREA_BYTES, and bytes outside an active area are consumed without effect.
module tcp_window_scale_option_parser #(
   parameter int unsigned MAX_AREA_BYTES = twsp_pkg::MAX_AREA_BYTES_DEF
) (
   input logic          clock,
   input logic          reset,
   twsp_req_if.sink     req_if,
   twsp_rsp_if.source   rsp_if
);
   import twsp_pkg::*;

   localparam logic [AREA_LEN_W-1:0] MaxArea = AREA_LEN_W'(MAX_AREA_BYTES);

   typedef enum logic [2:0] {
      PH_KIND,
      PH_LEN,
      PH_VALUE,
      PH_SKIP,
      PH_DONE
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [AREA_LEN_W-1:0] pos_ff, pos_in;
   logic [AREA_LEN_W-1:0] total_ff, total_in;
   logic [OPT_BYTE_W-1:0] kind_ff, kind_in;
   logic [AREA_LEN_W-1:0] skip_ff, skip_in;
   logic [SHIFT_W-1:0]    shift_ff, shift_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SHIFT_W-1:0]    rsp_shift_ff, rsp_shift_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic [SHIFT_W-1:0]    skid_shift_ff, skid_shift_in;

   logic                  accept;
   logic                  emit;
   logic [SHIFT_W-1:0]    emit_shift;
   logic                  out_fire;

   assign req_if.ready       = !skid_valid_ff;
   assign accept             = req_if.valid && !skid_valid_ff;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.window_shift = rsp_shift_ff;
   assign out_fire           = rsp_valid_ff && rsp_if.ready;

   // Per-byte parse step.
   always_comb begin
      logic [AREA_LEN_W-1:0] len_sat;
      logic [AREA_LEN_W:0]   pos_plus;
      logic [8:0]            opt_end;
      logic [OPT_BYTE_W-1:0] b;

      b          = req_if.opt_byte;
      len_sat    = (req_if.area_len > MaxArea) ? MaxArea : req_if.area_len;
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      total_in   = total_ff;
      kind_in    = kind_ff;
      skip_in    = skip_ff;
      shift_in   = shift_ff;
      emit       = 1'b0;
      emit_shift = '0;
      pos_plus   = '0;
      opt_end    = '0;

      if (accept) begin
         // A start byte abandons any unfinished area and opens a fresh parse.
         if (req_if.area_start) begin
            phase_in = PH_KIND;
            pos_in   = '0;
            total_in = len_sat;
            kind_in  = '0;
            skip_in  = '0;
            shift_in = '0;
         end

         if (req_if.area_start && (len_sat == '0)) begin
            emit = 1'b1;
         end else if (pos_in < total_in) begin
            pos_plus = {1'b0, pos_in} + 1'b1;
            // The option began one byte before its length byte.
            opt_end  = {3'b000, pos_in} - 9'd1 + {1'b0, b};
            case (phase_in)
               PH_KIND: begin
                  if (b == KIND_EOL) begin
                     phase_in = PH_DONE;
                  end else if (b == KIND_NOP) begin
                     phase_in = PH_KIND;
                  end else if (pos_plus >= {1'b0, total_in}) begin
                     phase_in = PH_DONE;
                  end else begin
                     kind_in  = b;
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  if ((b < MIN_OPT_LEN) || (opt_end > {3'b000, total_in})) begin
                     phase_in = PH_DONE;
                  end else if ((kind_in == KIND_WSCALE) && (b == WSCALE_LEN)) begin
                     phase_in = PH_VALUE;
                  end else if (b == MIN_OPT_LEN) begin
                     phase_in = PH_KIND;
                  end else begin
                     skip_in  = AREA_LEN_W'(b - MIN_OPT_LEN);
                     phase_in = PH_SKIP;
                  end
               end
               PH_VALUE: begin
                  shift_in = (b > SHIFT_CAP) ? SHIFT_W'(SHIFT_CAP) : SHIFT_W'(b);
                  phase_in = PH_DONE;
               end
               PH_SKIP: begin
                  skip_in = skip_in - 1'b1;
                  if (skip_in == '0) begin
                     phase_in = PH_KIND;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
            pos_in = pos_plus[AREA_LEN_W-1:0];
            if (pos_in == total_in) begin
               emit       = 1'b1;
               emit_shift = shift_in;
            end
         end
      end
   end

   // Output register with a skid entry behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_shift_in  = rsp_shift_ff;
      skid_valid_in = skid_valid_ff;
      skid_shift_in = skid_shift_ff;
      if (!rsp_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_shift_in  = skid_shift_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = emit;
            rsp_shift_in = emit_shift;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_shift_in = emit_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_KIND;
         pos_ff        <= '0;
         total_ff      <= '0;
         kind_ff       <= '0;
         skip_ff       <= '0;
         shift_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         total_ff      <= total_in;
         kind_ff       <= kind_in;
         skip_ff       <= skip_in;
         shift_ff      <= shift_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_shift_ff  <= rsp_shift_in;
      skid_shift_ff <= skid_shift_in;
   end

endmodule

>>> sim/tcp_wscale_checker.sv
// Scoreboard for the window-scale parser: predicts each area's shift and compares results.
`timescale 1ns / 1ps

module tcp_wscale_checker #(
   parameter int unsigned MAX_AREA_BYTES = twsp_pkg::MAX_AREA_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   twsp_req_if         req_mon,
   twsp_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned shifts_pending
);
   import twsp_pkg::*;

   typedef enum logic [2:0] {
      SEEK_KIND,
      READ_LEN,
      READ_SHIFT,
      SKIP_BODY,
      PARSE_DONE
   } parse_phase_type;

   parse_phase_type       phase;
   logic [AREA_LEN_W-1:0] byte_pos;
   logic [AREA_LEN_W-1:0] area_total;
   logic [OPT_BYTE_W-1:0] opt_kind;
   logic [AREA_LEN_W-1:0] skip_left;
   logic [SHIFT_W-1:0]    held_shift;

   logic [SHIFT_W-1:0]    expected_shifts[$];
   int unsigned           fails = 0;

   function automatic void restart_parse();
      phase      = SEEK_KIND;
      byte_pos   = '0;
      opt_kind   = '0;
      skip_left  = '0;
      held_shift = '0;
   endfunction

   // Advances the parse by one byte; returns 1 when the byte closes an area.
   function automatic bit predict_shift(input logic [OPT_BYTE_W-1:0] b, input logic start,
                                        input logic [AREA_LEN_W-1:0] len_in,
                                        output logic [SHIFT_W-1:0] shift);
      int unsigned len;
      int unsigned p;
      len   = len_in;
      shift = '0;
      if (start) begin
         restart_parse();
         if (len > MAX_AREA_BYTES) len = MAX_AREA_BYTES;
         area_total = len[AREA_LEN_W-1:0];
         if (len == 0) return 1'b1;
      end
      if (byte_pos >= area_total) return 1'b0;
      p = byte_pos;
      case (phase)
         SEEK_KIND: begin
            if (b == KIND_EOL) begin
               phase = PARSE_DONE;
            end else if (b != KIND_NOP) begin
               // A kind on the last byte leaves no room for its length.
               if (p + 1 >= area_total) begin
                  phase = PARSE_DONE;
               end else begin
                  opt_kind = b;
                  phase    = READ_LEN;
               end
            end
         end
         READ_LEN: begin
            // The option started on the previous byte.
            if (b < MIN_OPT_LEN || (p - 1) + b > area_total) begin
               phase = PARSE_DONE;
            end else if (opt_kind == KIND_WSCALE && b == WSCALE_LEN) begin
               phase = READ_SHIFT;
            end else if (b == MIN_OPT_LEN) begin
               phase = SEEK_KIND;
            end else begin
               skip_left = 6'(b - MIN_OPT_LEN);
               phase     = SKIP_BODY;
            end
         end
         READ_SHIFT: begin
            held_shift = (b > SHIFT_CAP) ? SHIFT_CAP[SHIFT_W-1:0] : b[SHIFT_W-1:0];
            phase      = PARSE_DONE;
         end
         SKIP_BODY: begin
            skip_left = skip_left - 1'b1;
            if (skip_left == 0) phase = SEEK_KIND;
         end
         default: phase = PARSE_DONE;
      endcase
      byte_pos = byte_pos + 1'b1;
      if (byte_pos == area_total) begin
         shift = held_shift;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      logic [SHIFT_W-1:0] want;
      logic [SHIFT_W-1:0] got;
      if (reset) begin
         restart_parse();
         area_total = '0;
         expected_shifts.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_shifts.size() == 0) begin
               $error("window_shift %0d arrived with no expectation waiting",
                      rsp_mon.window_shift);
               fails++;
            end else begin
               want = expected_shifts.pop_front();
               if (rsp_mon.window_shift !== want) begin
                  $error("window_shift mismatch: expected %0d, actual %0d",
                         want, rsp_mon.window_shift);
                  fails++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (predict_shift(req_mon.opt_byte, req_mon.area_start, req_mon.area_len, got))
               expected_shifts.push_back(got);
         end
      end
      fail_count     <= fails;
      shifts_pending <= expected_shifts.size();
   end

endmodule

>>> sim/tb_tcp_window_scale_option_parser.sv
// Testbench top for the TCP window-scale option parser: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_tcp_window_scale_option_parser;
   import twsp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_ITEMS = 1700;
   localparam int unsigned HOLD_CYCLES  = 200;

   logic clock;
   logic reset;

   twsp_req_if req_if ();
   twsp_rsp_if rsp_if ();

   int unsigned fail_count;
   int unsigned shifts_pending;
   int unsigned cycle_count   = 0;
   int unsigned req_idle_pct  = 0;
   int unsigned rsp_idle_pct  = 0;
   int unsigned hold_requests = 0;

   logic [OPT_BYTE_W-1:0] area_q[$];

   tcp_window_scale_option_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   tcp_wscale_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .fail_count     (fail_count),
      .shifts_pending (shifts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      int unsigned holds_served;
      int unsigned hold_left;
      holds_served = 0;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99, 0) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_item(input logic [OPT_BYTE_W-1:0] b, input logic start,
                            input logic [AREA_LEN_W-1:0] len);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.opt_byte   <= b;
      req_if.area_start <= start;
      req_if.area_len   <= len;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Sends the first n bytes of area_q; only the first carries the start mark and the area length.
   task automatic send_area(input logic [AREA_LEN_W-1:0] len, input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         send_item(area_q[i], i == 0, (i == 0) ? len : AREA_LEN_W'($urandom_range(63, 0)));
   endtask

   // Waits with the request side quiet until every expected shift has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (shifts_pending != 0);
   endtask

   task automatic build_random_area(output logic [AREA_LEN_W-1:0] len, output int unsigned n);
      int unsigned pick;
      int unsigned r;
      int unsigned total;
      int unsigned room;
      int unsigned olen;
      int unsigned cap;
      area_q.delete();
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
         area_q.push_back(OPT_BYTE_W'($urandom_range(255, 0)));
         len = '0;
         n   = 1;
         return;
      end
      r = $urandom_range(99, 0);
      if (r < 75) total = $urandom_range(12, 1);
      else if (r < 95) total = $urandom_range(40, 13);
      else total = MAX_AREA_BYTES_DEF;
      len = AREA_LEN_W'(total);
      // Lengths beyond the maximum are clipped, so such an area still ends after 40 bytes.
      if (r >= 95) len = AREA_LEN_W'($urandom_range(63, MAX_AREA_BYTES_DEF + 1));
      if (pick < 23) begin
         while (area_q.size() < total) area_q.push_back(OPT_BYTE_W'($urandom_range(255, 0)));
      end else begin
         while (area_q.size() < total) begin
            room = total - area_q.size();
            r    = $urandom_range(99, 0);
            if (r < 20) begin
               area_q.push_back(KIND_NOP);
            end else if (r < 45 && room >= 3) begin
               area_q.push_back(KIND_WSCALE);
               area_q.push_back(WSCALE_LEN);
               area_q.push_back(OPT_BYTE_W'($urandom_range(99, 0) < 50 ?
                                            $urandom_range(14, 0) : $urandom_range(255, 0)));
            end else if (r < 50) begin
               area_q.push_back(KIND_EOL);
            end else if (r < 60) begin
               area_q.push_back(OPT_BYTE_W'($urandom_range(255, 0)));
            end else if (room >= 2) begin
               // The length may overshoot the area by one byte now and then.
               cap  = (room < 9) ? room : 9;
               olen = $urandom_range(cap + 1, 2);
               area_q.push_back(OPT_BYTE_W'($urandom_range(255, 2)));
               area_q.push_back(OPT_BYTE_W'(olen));
               for (int unsigned k = 2; k < olen && area_q.size() < total; k++)
                  area_q.push_back(OPT_BYTE_W'($urandom_range(255, 0)));
            end else begin
               area_q.push_back(KIND_NOP);
            end
         end
         if (pick < 31) area_q[$urandom_range(total - 1, 0)] = OPT_BYTE_W'($urandom_range(255, 0));
      end
      n = total;
      // Some areas are cut short and abandoned by the next start byte.
      if (pick >= 95) n = $urandom_range(total, 1);
   endtask

   initial begin
      logic [AREA_LEN_W-1:0] len;
      int unsigned n;
      int unsigned sent;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.opt_byte   = '0;
      req_if.area_start = 1'b0;
      req_if.area_len   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 15;
      rsp_idle_pct <= 79;

      // A byte while no area is open is ignored.
      send_item(8'hAA, 1'b0, 6'd5);
      // An empty area answers at once.
      send_item(8'h03, 1'b1, 6'd0);
      // No-operation, then a window scale whose value is capped.
      area_q = '{KIND_NOP, KIND_WSCALE, WSCALE_LEN, 8'hFF};
      send_area(6'd4, 4);
      // End-of-list stops the parse before a window scale.
      area_q = '{KIND_EOL, KIND_WSCALE, WSCALE_LEN, 8'h05};
      send_area(6'd4, 4);
      // Length below two is malformed.
      area_q = '{8'h05, 8'h01};
      send_area(6'd2, 2);
      // Another option skipped by its length, then a window scale.
      area_q = '{8'h08, 8'h03, 8'h55, KIND_WSCALE, WSCALE_LEN, 8'h0B};
      send_area(6'd6, 6);
      // A kind on the last byte has no room for its length.
      area_q = '{KIND_NOP, KIND_NOP, 8'h05};
      send_area(6'd3, 3);
      // A new start byte abandons the open area.
      area_q = '{KIND_NOP};
      send_area(6'd9, 1);
      area_q = '{KIND_WSCALE, WSCALE_LEN, 8'h02};
      send_area(6'd3, 3);
      drain_results();

      sent = 0;
      for (int unsigned mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 15;
               rsp_idle_pct <= 79;
            end
            1: begin
               req_idle_pct = 79;
               rsp_idle_pct <= 15;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct <= 0;
               // Long result hold-off while empty areas pile up behind it.
               hold_requests <= hold_requests + 1;
               for (int unsigned k = 0; k < 12; k++)
                  send_item(OPT_BYTE_W'($urandom_range(255, 0)), 1'b1, 6'd0);
            end
         endcase
         while (sent < (mode + 1) * RANDOM_ITEMS / 3) begin
            build_random_area(len, n);
            send_area(len, n);
            sent += n;
            if ($urandom_range(99, 0) < 5)
               send_item(OPT_BYTE_W'($urandom_range(255, 0)), 1'b0,
                         AREA_LEN_W'($urandom_range(63, 0)));
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && shifts_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/twsp_pkg.sv
hw/rtl/twsp_if.sv
hw/rtl/tcp_window_scale_option_parser.sv
sim/tcp_wscale_checker.sv
sim/tb_tcp_window_scale_option_parser.sv
